>>> rtl/core/acpd_pkg.sv
// ----------------------------------------------------------------------------
// acpd_pkg
// Shared codes, register indexes, reset values and arithmetic widths of the
// AC phase-angle dimmer scheduler.
// ----------------------------------------------------------------------------
package acpd_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned REG_W = 16;
  localparam int unsigned IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_CROSSING = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;

  localparam logic [IDX_W-1:0] REG_MIN_DELAY = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DELAY = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd2;

  localparam logic [REG_W-1:0] MIN_DELAY_RST = 16'd500;
  localparam logic [REG_W-1:0] MAX_DELAY_RST = 16'd8800;
  localparam logic [REG_W-1:0] DEBOUNCE_RST  = 16'd1000;
  localparam logic [REG_W-1:0] COUNT_MAX     = 16'hFFFF;

  // Multiplier operand widths: |level * (min - max)| < 2^24, reciprocal < 2^25
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // ceil(2^32 / 255): (x * RECIP_255) >> 32 equals x div 255 for x < 2^24
  localparam logic [MUL_B_W-1:0] RECIP_255   = 25'd16843010;
  localparam int unsigned        RECIP_SHIFT = 32;

endpackage

>>> rtl/core/acpd_ram.sv
// ----------------------------------------------------------------------------
// acpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/acpd_mul.sv
// ----------------------------------------------------------------------------
// acpd_mul
// Shared unsigned multiplier with a registered product, used for the level
// scaling and for the reciprocal division by 255.
// ----------------------------------------------------------------------------
module acpd_mul
  import acpd_pkg::*;
(
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/ac_phase_dimmer_scheduler.sv
// ----------------------------------------------------------------------------
// ac_phase_dimmer_scheduler
// Multi-channel triac phase-angle dimmer: double-buffered delay banks, zero
// crossing debounce and a serial per-tick scan of the front bank.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | sink      | in_valid_i / in_stall_o    | operation, channel, red, green,
//          |           |                            | blue, commit
//  out     | source    | out_valid_o / out_stall_i  | gates, crossing_accepted,
//          |           |                            | gates_changed
//  cfg     | sink      | cfg_we_i                   | cfg_index_i, cfg_data_i
//
//  An armed tick scans one bank entry per cycle through the RAM read port.
//  A write with nonzero brightness to a channel in range runs four passes
//  through the shared multiplier. One item at a time; a held result does
//  not block the next item's work. Reset clears all banks to disabled at
//  once through per-entry enable flops.
// ----------------------------------------------------------------------------
module ac_phase_dimmer_scheduler
  import acpd_pkg::*;
#(
  parameter int unsigned CHANNELS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [4:0]       channel_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic             commit_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      gates_o,
  output logic             crossing_accepted_o,
  output logic             gates_changed_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam int unsigned ACT_CH = (CHANNELS < 32) ? CHANNELS : 32;
  localparam int unsigned CW     = (ACT_CH > 1) ? $clog2(ACT_CH) : 1;
  localparam int unsigned AW     = CW + 1;
  localparam int unsigned ENT    = 2 ** AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_W0   = 3'd2;
  localparam logic [2:0] S_W1   = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_W3   = 3'd5;
  localparam logic [2:0] S_W4   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              bank_sel_q, bank_sel_d;
  logic              frame_rdy_q, frame_rdy_d;
  logic [REG_W-1:0]  elapsed_q, elapsed_d;
  logic              armed_q, armed_d;
  logic [ACT_CH-1:0] gate_q, gate_d;
  logic [ENT-1:0]    en_q, en_d;
  logic [REG_W-1:0]  min_q, min_d;
  logic [REG_W-1:0]  max_q, max_d;
  logic [REG_W-1:0]  deb_q, deb_d;
  logic [CW:0]       scan_q, scan_d;
  logic              proc_vld_q, proc_vld_d;
  logic [CW-1:0]     proc_idx_q, proc_idx_d;
  logic              acc_q, acc_d;
  logic              chg_q, chg_d;
  logic              out_valid_q, out_valid_d;

  logic [CW-1:0]     ch_q;
  logic [7:0]        level_q;
  logic [REG_W-1:0]  on_q;
  logic [31:0]       out_gates_q;
  logic              out_acc_q;
  logic              out_chg_q;

  logic              accept;
  logic              out_load;
  logic [7:0]        level_in;
  logic              ch_in_range;
  logic              lo_ge;
  logic [REG_W-1:0]  dmag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [REG_W-1:0]  quot;
  logic [REG_W-1:0]  delay_res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              ent_en;
  logic              gate_old;
  logic              gate_new;
  logic              tick_end;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    level_in = red_i;
    if (green_i > level_in) begin
      level_in = green_i;
    end
    if (blue_i > level_in) begin
      level_in = blue_i;
    end
  end

  assign ch_in_range = (32'(channel_i) < CHANNELS);
  assign lo_ge       = (min_q >= max_q);
  assign dmag        = lo_ge ? (min_q - max_q) : (max_q - min_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_W0: begin
        mul_a = MUL_A_W'(level_q);
        mul_b = MUL_B_W'(dmag);
      end
      S_W2: begin
        mul_a = MUL_A_W'(level_q - 8'd1);
        mul_b = MUL_B_W'(dmag);
      end
      S_W1, S_W3: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = RECIP_255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  acpd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign quot      = mul_p[RECIP_SHIFT +: REG_W];
  assign delay_res = lo_ge ? (max_q + quot) : (max_q - quot);

  assign ram_we    = (state_q == S_W4);
  assign ram_waddr = {~bank_sel_q, ch_q};
  assign ram_raddr = {bank_sel_q, scan_q[CW-1:0]};

  acpd_ram #(
    .WIDTH (32),
    .DEPTH (ENT)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({on_q, delay_res}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_en   = en_q[{bank_sel_q, proc_idx_q}];
  assign gate_old = gate_q[proc_idx_q];

  always_comb begin
    gate_new = gate_old;
    if (ent_en && (ram_rdata[31:16] == elapsed_q)) begin
      gate_new = 1'b1;
    end
    if (ent_en && (ram_rdata[15:0] == elapsed_q)) begin
      gate_new = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    bank_sel_d  = bank_sel_q;
    frame_rdy_d = frame_rdy_q;
    elapsed_d   = elapsed_q;
    armed_d     = armed_q;
    gate_d      = gate_q;
    en_d        = en_q;
    min_d       = min_q;
    max_d       = max_q;
    deb_d       = deb_q;
    scan_d      = scan_q;
    proc_vld_d  = 1'b0;
    proc_idx_d  = proc_idx_q;
    acc_d       = acc_q;
    chg_d       = chg_q;
    out_valid_d = out_valid_q && out_stall_i;
    tick_end    = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_DELAY: min_d = cfg_data_i;
        REG_MAX_DELAY: max_d = cfg_data_i;
        REG_DEBOUNCE:  deb_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          acc_d   = 1'b0;
          chg_d   = 1'b0;
          state_d = S_DONE;
          case (operation_i)
            OP_TICK: begin
              if (armed_q) begin
                scan_d  = '0;
                state_d = S_SCAN;
              end else begin
                tick_end = 1'b1;
              end
            end
            OP_CROSSING: begin
              if (elapsed_q >= deb_q) begin
                acc_d     = 1'b1;
                elapsed_d = '0;
                armed_d   = 1'b1;
                if (frame_rdy_q) begin
                  bank_sel_d  = ~bank_sel_q;
                  frame_rdy_d = 1'b0;
                end
              end
            end
            OP_WRITE: begin
              if (commit_i) begin
                frame_rdy_d = 1'b1;
              end
              if (ch_in_range) begin
                if (level_in == 8'd0) begin
                  en_d[{~bank_sel_q, channel_i[CW-1:0]}] = 1'b0;
                end else begin
                  state_d = S_W0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (proc_vld_q) begin
          gate_d[proc_idx_q] = gate_new;
          if (gate_new != gate_old) begin
            chg_d = 1'b1;
          end
        end
        if (scan_q != (CW+1)'(ACT_CH)) begin
          proc_vld_d = 1'b1;
          proc_idx_d = scan_q[CW-1:0];
          scan_d     = scan_q + 1'b1;
        end else begin
          tick_end = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_W0: state_d = S_W1;
      S_W1: state_d = S_W2;
      S_W2: state_d = S_W3;
      S_W3: state_d = S_W4;
      S_W4: begin
        en_d[ram_waddr] = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (tick_end) begin
      if (elapsed_q == COUNT_MAX) begin
        armed_d = 1'b0;
      end else begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_sel_q  <= 1'b0;
      frame_rdy_q <= 1'b0;
      elapsed_q   <= '0;
      armed_q     <= 1'b0;
      gate_q      <= '0;
      en_q        <= '0;
      min_q       <= MIN_DELAY_RST;
      max_q       <= MAX_DELAY_RST;
      deb_q       <= DEBOUNCE_RST;
      scan_q      <= '0;
      proc_vld_q  <= 1'b0;
      proc_idx_q  <= '0;
      acc_q       <= 1'b0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_sel_q  <= bank_sel_d;
      frame_rdy_q <= frame_rdy_d;
      elapsed_q   <= elapsed_d;
      armed_q     <= armed_d;
      gate_q      <= gate_d;
      en_q        <= en_d;
      min_q       <= min_d;
      max_q       <= max_d;
      deb_q       <= deb_d;
      scan_q      <= scan_d;
      proc_vld_q  <= proc_vld_d;
      proc_idx_q  <= proc_idx_d;
      acc_q       <= acc_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q    <= channel_i[CW-1:0];
      level_q <= level_in;
    end
    if (state_q == S_W2) begin
      on_q <= delay_res;
    end
    if (out_load) begin
      out_gates_q <= 32'(gate_q);
      out_acc_q   <= acc_q;
      out_chg_q   <= chg_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign gates_o             = out_gates_q;
  assign crossing_accepted_o = out_acc_q;
  assign gates_changed_o     = out_chg_q;

`ifndef SYNTHESIS
  a_scan_needs_armed : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> armed_q
  ) else $error("bank scan running while not armed");

  a_gates_only_in_scan : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |=> $stable(gate_q)
  ) else $error("gate levels changed outside a tick scan");

  a_write_back_bank : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr[AW-1] != bank_sel_q)
  ) else $error("delay write aimed at the front bank");

  a_flags_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(crossing_accepted_o && gates_changed_o)
  ) else $error("crossing and gate change flagged on one item");
`endif

endmodule
